/* rtl/urxr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the serial receive ring with error sentinel.
// Used by the controller, the datapath and the top level; depends on nothing.
package urxr_pkg;

  localparam int unsigned RING_DEPTH = 512;
  localparam int unsigned IDX_W      = $clog2(RING_DEPTH);
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned CNT_W      = 32;

  localparam logic [DATA_W-1:0] SENTINEL_BYTE = 8'h01;

  // Item command codes
  localparam logic CMD_RX  = 1'b0;
  localparam logic CMD_POP = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Controller to datapath commands
  typedef struct packed {
    logic push;  // store the received item (byte or sentinel)
    logic pop;   // read and remove the oldest byte if any
    logic load;  // copy the item's result into the output register
  } cmd_t;

endpackage

/* rtl/urxr_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences one item through accept and result load.
// Depends on urxr_pkg for the command codes and the command struct.
module urxr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           command_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output urxr_pkg::cmd_t cmd_o
);
  import urxr_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign load        = (state_q == S_LOAD) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  // Decode the accepted item into datapath commands
  always_comb begin
    cmd_o.push = in_acc && (command_i == CMD_RX);
    cmd_o.pop  = in_acc && (command_i == CMD_POP);
    cmd_o.load = load;
  end

  // Next state and output valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (load) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/urxr_dp.sv */
`timescale 1ns / 1ps
// Datapath: ring memory, read/write indices, diagnostic counters, result register.
// Depends on urxr_pkg for widths, the sentinel byte and the command struct.
module urxr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  urxr_pkg::cmd_t                cmd_i,
  input  logic [urxr_pkg::DATA_W-1:0]   rx_data_i,
  input  logic                          overrun_flag_i,
  input  logic                          noise_flag_i,
  input  logic                          framing_flag_i,
  input  logic                          parity_flag_i,
  output logic [urxr_pkg::DATA_W-1:0]   pop_data_o,
  output logic                          pop_valid_o,
  output logic [urxr_pkg::CNT_W-1:0]    bytes_pushed_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    overflow_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    overrun_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    noise_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    framing_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    parity_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    sentinel_count_o
);
  import urxr_pkg::*;

  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  idx_t wr_idx_q, wr_idx_d;
  idx_t rd_idx_q, rd_idx_d;
  logic hit_q, hit_d;
  cnt_t pushed_q, pushed_d;
  cnt_t dropped_q, dropped_d;
  cnt_t overrun_q, overrun_d;
  cnt_t noise_q, noise_d;
  cnt_t framing_q, framing_d;
  cnt_t parity_q, parity_d;
  cnt_t inserted_q, inserted_d;

  idx_t              wr_next;
  idx_t              rd_next;
  logic              err_any;
  logic              full;
  logic              not_empty;
  logic [DATA_W-1:0] wr_byte;

  function automatic idx_t advance(idx_t idx);
    advance = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign wr_next   = advance(wr_idx_q);
  assign rd_next   = advance(rd_idx_q);
  assign full      = (wr_next == rd_idx_q);
  assign not_empty = (rd_idx_q != wr_idx_q);
  assign err_any   = overrun_flag_i | noise_flag_i | framing_flag_i | parity_flag_i;
  assign wr_byte   = err_any ? SENTINEL_BYTE : rx_data_i;

  // Index and counter updates for the accepted item
  always_comb begin
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    hit_d      = hit_q;
    pushed_d   = pushed_q;
    dropped_d  = dropped_q;
    overrun_d  = overrun_q;
    noise_d    = noise_q;
    framing_d  = framing_q;
    parity_d   = parity_q;
    inserted_d = inserted_q;
    if (cmd_i.push) begin
      hit_d    = 1'b0;
      wr_idx_d = wr_next;
      pushed_d = pushed_q + 1'b1;
      // drop the oldest byte on a full ring
      if (full) begin
        rd_idx_d  = rd_next;
        dropped_d = dropped_q + 1'b1;
      end
      if (overrun_flag_i) overrun_d = overrun_q + 1'b1;
      if (noise_flag_i)   noise_d   = noise_q + 1'b1;
      if (framing_flag_i) framing_d = framing_q + 1'b1;
      if (parity_flag_i)  parity_d  = parity_q + 1'b1;
      if (err_any)        inserted_d = inserted_q + 1'b1;
    end else if (cmd_i.pop) begin
      hit_d = not_empty;
      if (not_empty) begin
        rd_idx_d = rd_next;
      end
    end
  end

  // Hold indices and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      hit_q      <= 1'b0;
      pushed_q   <= '0;
      dropped_q  <= '0;
      overrun_q  <= '0;
      noise_q    <= '0;
      framing_q  <= '0;
      parity_q   <= '0;
      inserted_q <= '0;
    end else begin
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      hit_q      <= hit_d;
      pushed_q   <= pushed_d;
      dropped_q  <= dropped_d;
      overrun_q  <= overrun_d;
      noise_q    <= noise_d;
      framing_q  <= framing_d;
      parity_q   <= parity_d;
      inserted_q <= inserted_d;
    end
  end

  // Ring memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ring_mem[wr_idx_q] <= wr_byte;
    end
    if (cmd_i.pop && not_empty) begin
      rd_data_q <= ring_mem[rd_idx_q];
    end
  end

  // Result register, loaded once the item's updates have settled
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pop_data_o           <= hit_q ? rd_data_q : '0;
      pop_valid_o          <= hit_q;
      bytes_pushed_count_o <= pushed_q;
      overflow_count_o     <= dropped_q;
      overrun_count_o      <= overrun_q;
      noise_count_o        <= noise_q;
      framing_count_o      <= framing_q;
      parity_count_o       <= parity_q;
      sentinel_count_o     <= inserted_q;
    end
  end

endmodule

/* rtl/uart_rx_ring_with_error_sentinel.sv */
`timescale 1ns / 1ps
// Each item is taken in S_IDLE, where the accept step updates the ring, its indices and
// the counters and starts the registered ring read of a pop; then S_LOAD copies
// the result into the output register. A new item is taken while a finished result
// still waits on the output side; the result register stalls only the load step.
// A receive item stores its byte, or the sentinel 0x01 when any line-error flag is
// set; a full ring drops its oldest byte. Counters wrap at 32 bits.
// Top level: joins the controller and the datapath; depends on urxr_pkg.
module uart_rx_ring_with_error_sentinel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [urxr_pkg::DATA_W-1:0]   rx_data_i,
  input  logic                          overrun_flag_i,
  input  logic                          noise_flag_i,
  input  logic                          framing_flag_i,
  input  logic                          parity_flag_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [urxr_pkg::DATA_W-1:0]   pop_data_o,
  output logic                          pop_valid_o,
  output logic [urxr_pkg::CNT_W-1:0]    bytes_pushed_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    overflow_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    overrun_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    noise_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    framing_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    parity_count_o,
  output logic [urxr_pkg::CNT_W-1:0]    sentinel_count_o
);
  import urxr_pkg::*;

  cmd_t cmd;

  // Sequence items
  urxr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Ring, counters and result register
  urxr_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .rx_data_i            (rx_data_i),
    .overrun_flag_i       (overrun_flag_i),
    .noise_flag_i         (noise_flag_i),
    .framing_flag_i       (framing_flag_i),
    .parity_flag_i        (parity_flag_i),
    .pop_data_o           (pop_data_o),
    .pop_valid_o          (pop_valid_o),
    .bytes_pushed_count_o (bytes_pushed_count_o),
    .overflow_count_o     (overflow_count_o),
    .overrun_count_o      (overrun_count_o),
    .noise_count_o        (noise_count_o),
    .framing_count_o      (framing_count_o),
    .parity_count_o       (parity_count_o),
    .sentinel_count_o     (sentinel_count_o)
  );

endmodule

/* rtl/urxr_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the serial receive ring, bound to the top level.
// Depends on urxr_pkg for widths.
module urxr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [urxr_pkg::DATA_W-1:0]   pop_data_o,
  input logic                          pop_valid_o,
  input logic [urxr_pkg::CNT_W-1:0]    bytes_pushed_count_o
);
  import urxr_pkg::*;

  // Drop ready for the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high right after an accepted item");

  // A result only rises after the input side has been busy
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in progress");

  // A result without a popped byte carries zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pop_valid_o |-> pop_data_o == '0)
    else $error("nonzero pop data without pop valid");

  // Hold a stalled result
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pop_data_o)
      && $stable(pop_valid_o) && $stable(bytes_pushed_count_o))
    else $error("stalled result changed");

endmodule

bind uart_rx_ring_with_error_sentinel urxr_checker u_urxr_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_ready_o           (in_ready_o),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .pop_data_o           (pop_data_o),
  .pop_valid_o          (pop_valid_o),
  .bytes_pushed_count_o (bytes_pushed_count_o)
);

/* sim/uart_rx_ring_with_error_sentinel_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for the serial receive ring with error sentinel: directed table,
// then push/pop bursts that overflow and drain the ring, checked by a built-in model.
// Depends on urxr_pkg and the uart_rx_ring_with_error_sentinel top level.
module uart_rx_ring_with_error_sentinel_test;
  import urxr_pkg::*;

  localparam logic [3:0] ERR_NONE = 4'b0000;
  localparam logic [3:0] ERR_OVR  = 4'b1000;
  localparam logic [3:0] ERR_NOI  = 4'b0100;
  localparam logic [3:0] ERR_FRM  = 4'b0010;
  localparam logic [3:0] ERR_PAR  = 4'b0001;
  localparam logic [3:0] ERR_ALL  = 4'b1111;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [DATA_W-1:0] pop_data;
    logic              pop_valid;
    cnt_t              pushed;
    cnt_t              dropped;
    cnt_t              overrun;
    cnt_t              noise;
    cnt_t              framing;
    cnt_t              parity;
    cnt_t              sentinel;
  } ring_result_t;

  typedef struct packed {
    logic              cmd;
    logic [DATA_W-1:0] data;
    logic [3:0]        errs;
    logic              typed;   // result below is known by hand
    ring_result_t      result;
  } stim_row_t;

  // Directed items: empty pops, byte extremes, each flag alone and together
  localparam int unsigned DIRECTED_ROWS = 24;
  localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
    '{CMD_POP, 8'h00, ERR_NONE, 1'b1, '{8'h00, 1'b0, 0, 0, 0, 0, 0, 0, 0}},
    '{CMD_RX,  8'h00, ERR_NONE, 1'b1, '{8'h00, 1'b0, 1, 0, 0, 0, 0, 0, 0}},
    '{CMD_RX,  8'hFF, ERR_NONE, 1'b1, '{8'h00, 1'b0, 2, 0, 0, 0, 0, 0, 0}},
    '{CMD_POP, 8'hFF, ERR_ALL,  1'b1, '{8'h00, 1'b1, 2, 0, 0, 0, 0, 0, 0}},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b1, '{8'hFF, 1'b1, 2, 0, 0, 0, 0, 0, 0}},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b1, '{8'h00, 1'b0, 2, 0, 0, 0, 0, 0, 0}},
    '{CMD_RX,  8'hA5, ERR_OVR,  1'b1, '{8'h00, 1'b0, 3, 0, 1, 0, 0, 0, 1}},
    '{CMD_RX,  8'h5A, ERR_NOI,  1'b1, '{8'h00, 1'b0, 4, 0, 1, 1, 0, 0, 2}},
    '{CMD_RX,  8'h3C, ERR_FRM,  1'b1, '{8'h00, 1'b0, 5, 0, 1, 1, 1, 0, 3}},
    '{CMD_RX,  8'hC3, ERR_PAR,  1'b1, '{8'h00, 1'b0, 6, 0, 1, 1, 1, 1, 4}},
    '{CMD_RX,  8'hFF, ERR_ALL,  1'b1, '{8'h00, 1'b0, 7, 0, 2, 2, 2, 2, 5}},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b1, '{8'h01, 1'b1, 7, 0, 2, 2, 2, 2, 5}},
    '{CMD_RX,  8'h01, ERR_NONE, 1'b1, '{8'h00, 1'b0, 8, 0, 2, 2, 2, 2, 5}},
    '{CMD_RX,  8'h80, ERR_OVR | ERR_PAR, 1'b1,
      '{8'h00, 1'b0, 9, 0, 3, 2, 2, 3, 6}},
    '{CMD_RX,  8'h7F, ERR_NOI | ERR_FRM, 1'b1,
      '{8'h00, 1'b0, 10, 0, 3, 3, 3, 3, 7}},
    '{CMD_RX,  8'h55, ERR_NONE, 1'b0, '0},
    '{CMD_RX,  8'hAA, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0},
    '{CMD_POP, 8'h00, ERR_NONE, 1'b0, '0}
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_ready_o;
  logic              command_i      = CMD_RX;
  logic [DATA_W-1:0] rx_data_i      = '0;
  logic              overrun_flag_i = 1'b0;
  logic              noise_flag_i   = 1'b0;
  logic              framing_flag_i = 1'b0;
  logic              parity_flag_i  = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i    = 1'b0;
  logic [DATA_W-1:0] pop_data_o;
  logic              pop_valid_o;
  cnt_t              bytes_pushed_count_o;
  cnt_t              overflow_count_o;
  cnt_t              overrun_count_o;
  cnt_t              noise_count_o;
  cnt_t              framing_count_o;
  cnt_t              parity_count_o;
  cnt_t              sentinel_count_o;

  // Model state of the ring and its counters
  logic [DATA_W-1:0] ring_bytes [RING_DEPTH];
  idx_t              ring_wr = '0;
  idx_t              ring_rd = '0;
  ring_result_t      ring_counts = '0;

  ring_result_t      pending_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       random_sent = 0;
  logic              calm = 1'b0;

  uart_rx_ring_with_error_sentinel dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .command_i           (command_i),
    .rx_data_i           (rx_data_i),
    .overrun_flag_i      (overrun_flag_i),
    .noise_flag_i        (noise_flag_i),
    .framing_flag_i      (framing_flag_i),
    .parity_flag_i       (parity_flag_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .pop_data_o          (pop_data_o),
    .pop_valid_o         (pop_valid_o),
    .bytes_pushed_count_o(bytes_pushed_count_o),
    .overflow_count_o    (overflow_count_o),
    .overrun_count_o     (overrun_count_o),
    .noise_count_o       (noise_count_o),
    .framing_count_o     (framing_count_o),
    .parity_count_o      (parity_count_o),
    .sentinel_count_o    (sentinel_count_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic idx_t next_slot(input idx_t slot);
    return (slot == idx_t'(RING_DEPTH - 1)) ? '0 : slot + 1'b1;
  endfunction

  // Store one byte, dropping the oldest entry when the ring is full
  function automatic void ring_push(input logic [DATA_W-1:0] value);
    idx_t nxt;
    nxt = next_slot(ring_wr);
    if (nxt == ring_rd) begin
      ring_rd = next_slot(ring_rd);
      ring_counts.dropped = ring_counts.dropped + 1'b1;
    end
    ring_bytes[ring_wr] = value;
    ring_wr = nxt;
    ring_counts.pushed = ring_counts.pushed + 1'b1;
  endfunction

  // Advance the model by one item and return the result it should produce
  function automatic ring_result_t ring_apply(input logic cmd, input logic [DATA_W-1:0] data,
                                              input logic [3:0] errs);
    ring_result_t res;
    logic [DATA_W-1:0] popped;
    logic hit;
    popped = '0;
    hit = 1'b0;
    if (cmd == CMD_RX) begin
      if (errs != ERR_NONE) begin
        if ((errs & ERR_OVR) != 0) ring_counts.overrun = ring_counts.overrun + 1'b1;
        if ((errs & ERR_NOI) != 0) ring_counts.noise   = ring_counts.noise + 1'b1;
        if ((errs & ERR_FRM) != 0) ring_counts.framing = ring_counts.framing + 1'b1;
        if ((errs & ERR_PAR) != 0) ring_counts.parity  = ring_counts.parity + 1'b1;
        ring_push(SENTINEL_BYTE);
        ring_counts.sentinel = ring_counts.sentinel + 1'b1;
      end else begin
        ring_push(data);
      end
    end else if (ring_rd != ring_wr) begin
      popped = ring_bytes[ring_rd];
      ring_rd = next_slot(ring_rd);
      hit = 1'b1;
    end
    res = ring_counts;
    res.pop_data = popped;
    res.pop_valid = hit;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %08h, got %08h", $realtime, name, want, got);
    end
  endtask

  // Offer one item, hold it until taken, then log its expected result
  task automatic send_item(input logic cmd, input logic [DATA_W-1:0] data,
                           input logic [3:0] errs, input logic typed,
                           input ring_result_t typed_res);
    ring_result_t predicted;
    logic rdy;
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    rx_data_i      <= data;
    overrun_flag_i <= (errs & ERR_OVR) != 0;
    noise_flag_i   <= (errs & ERR_NOI) != 0;
    framing_flag_i <= (errs & ERR_FRM) != 0;
    parity_flag_i  <= (errs & ERR_PAR) != 0;
    rdy = 1'b0;
    while (!rdy) begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end
    predicted = ring_apply(cmd, data, errs);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random burst in which about push_pct percent of the items are receives
  task automatic send_phase(input int unsigned len, input int unsigned push_pct);
    logic cmd;
    logic [3:0] errs;
    for (int unsigned i = 0; i < len; i++) begin
      calm = (random_sent >= 400 && random_sent < 750);
      cmd = ($urandom_range(0, 99) < push_pct) ? CMD_RX : CMD_POP;
      errs = ($urandom_range(0, 99) < 25) ? 4'($urandom_range(1, 15)) : ERR_NONE;
      send_item(cmd, 8'($urandom_range(0, 255)), errs, 1'b0, '0);
      random_sent++;
    end
    calm = 1'b0;
  endtask

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 36);
  end

  // Compare each result that is taken against the oldest expectation
  always @(negedge clk_i) begin
    ring_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected", $realtime);
      end else begin
        want = pending_results.pop_front();
        check_field("pop_data", CNT_W'(want.pop_data), CNT_W'(pop_data_o));
        check_field("pop_valid", CNT_W'(want.pop_valid), CNT_W'(pop_valid_o));
        check_field("bytes_pushed_count", want.pushed, bytes_pushed_count_o);
        check_field("overflow_count", want.dropped, overflow_count_o);
        check_field("overrun_count", want.overrun, overrun_count_o);
        check_field("noise_count", want.noise, noise_count_o);
        check_field("framing_count", want.framing, framing_count_o);
        check_field("parity_count", want.parity, parity_count_o);
        check_field("sentinel_count", want.sentinel, sentinel_count_o);
      end
    end
  end

  initial begin
    #5ms;
    $display("uart_rx_ring_with_error_sentinel verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].errs,
                DIRECTED[i].typed, DIRECTED[i].result);
    end
    wait_for_drain();

    // Overfill the ring, drain it past empty, then mix
    send_phase(600, 95);
    wait_for_drain();
    send_phase(600, 5);
    while (random_sent < RANDOM_ITEMS) begin
      send_phase($urandom_range(50, 150), $urandom_range(20, 80));
    end

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("uart_rx_ring_with_error_sentinel verification clean");
    end else begin
      $display("uart_rx_ring_with_error_sentinel verification failed");
    end
    $finish;
  end

endmodule

/* uart_rx_ring_with_error_sentinel.f */
rtl/urxr_pkg.sv
rtl/urxr_ctrl.sv
rtl/urxr_dp.sv
rtl/uart_rx_ring_with_error_sentinel.sv
rtl/urxr_checker.sv
sim/uart_rx_ring_with_error_sentinel_test.sv
